FILE: src/thtc_pkg.sv
// Shared constants, types and helpers for the thermistor table converter.
`default_nettype none

package thtc_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 23;
    localparam int MEM_DEPTH     = 2 * TABLE_ENTRIES;
    localparam int ADDR_W        = $clog2(MEM_DEPTH);
    localparam int IDX_W         = $clog2(TABLE_ENTRIES + 1);

    // Temperature scale
    localparam int START_DEG  = -20;
    localparam int STEP_DEG   = 5;
    localparam int TENTHS     = 10;
    localparam int SEG_TENTHS = STEP_DEG * TENTHS;
    localparam int LOW_TENTHS = START_DEG * TENTHS;
    localparam int TOP_TENTHS = (START_DEG + STEP_DEG * (TABLE_ENTRIES - 1)) * TENTHS;
    localparam int OUT_MIN    = -1024;
    localparam int OUT_MAX    = 1023;

    // Field and datapath widths
    localparam int VAL_W  = 16;
    localparam int TEMP_W = 11;
    localparam int BASE_W = 13;
    localparam int QUO_W  = $clog2(SEG_TENTHS);
    localparam int NUM_W  = VAL_W + QUO_W;
    localparam int CNT_W  = $clog2(QUO_W);

    localparam logic signed [BASE_W-1:0] BASE_MAX = BASE_W'(OUT_MAX);
    localparam logic signed [BASE_W-1:0] BASE_MIN = BASE_W'(OUT_MIN);

    localparam logic signed [TEMP_W-1:0] LOW_SAT =
        TEMP_W'((LOW_TENTHS < OUT_MIN) ? OUT_MIN : LOW_TENTHS);
    localparam logic signed [TEMP_W-1:0] TOP_SAT =
        TEMP_W'((TOP_TENTHS > OUT_MAX) ? OUT_MAX : TOP_TENTHS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_LAST,
        S_RD_FIRST,
        S_CHK_FIRST,
        S_SCAN,
        S_MUL,
        S_DIV,
        S_FIN,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        ADDR_HOLD,
        ADDR_LAST,
        ADDR_ZERO,
        ADDR_IDX
    } addr_sel_t;

    typedef enum logic [2:0] {
        RES_HOLD,
        RES_LOW,
        RES_TOP,
        RES_ZERO,
        RES_INTERP
    } res_sel_t;

    typedef struct packed {
        logic      load;
        logic      latch;
        addr_sel_t addr_sel;
        logic      chk_last;
        logic      scan_init;
        logic      scan_adv;
        logic      scan_hit;
        logic      mul;
        logic      div_step;
        res_sel_t  res_sel;
    } cmd_t;

    typedef struct packed {
        logic gt_first;
        logic last_hit;
        logic seg_hit;
        logic scan_end;
        logic div_last;
    } status_t;

    function automatic logic signed [TEMP_W-1:0] sat_temp(
        input logic signed [BASE_W-1:0] v
    );
        logic signed [TEMP_W-1:0] r;
        if (v > BASE_MAX)
        begin
            r = TEMP_W'(OUT_MAX);
        end
        else if (v < BASE_MIN)
        begin
            r = TEMP_W'(OUT_MIN);
        end
        else
        begin
            r = v[TEMP_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/thtc_ctrl.sv
// Sequencer for table loads and conversions.
`default_nettype none

module thtc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              mode,
    input  wire thtc_pkg::status_t status,
    output thtc_pkg::cmd_t         cmd,
    output logic                   busy,
    output logic                   done
);

    thtc_pkg::state_t state_reg;
    thtc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= thtc_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.addr_sel  = thtc_pkg::ADDR_HOLD;
        cmd.res_sel   = thtc_pkg::RES_HOLD;
        case (state_reg)
            thtc_pkg::S_IDLE:
            begin
                if (start)
                begin
                    if (mode)
                    begin
                        cmd.load = 1'b1;
                    end
                    else
                    begin
                        cmd.latch  = 1'b1;
                        state_next = thtc_pkg::S_RD_LAST;
                    end
                end
            end
            thtc_pkg::S_RD_LAST:
            begin
                cmd.addr_sel = thtc_pkg::ADDR_LAST;
                state_next   = thtc_pkg::S_RD_FIRST;
            end
            thtc_pkg::S_RD_FIRST:
            begin
                cmd.addr_sel = thtc_pkg::ADDR_ZERO;
                cmd.chk_last = 1'b1;
                state_next   = thtc_pkg::S_CHK_FIRST;
            end
            thtc_pkg::S_CHK_FIRST:
            begin
                if (status.gt_first)
                begin
                    cmd.res_sel = thtc_pkg::RES_LOW;
                    state_next  = thtc_pkg::S_DONE;
                end
                else if (status.last_hit)
                begin
                    cmd.res_sel = thtc_pkg::RES_TOP;
                    state_next  = thtc_pkg::S_DONE;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    cmd.addr_sel  = thtc_pkg::ADDR_IDX;
                    state_next    = thtc_pkg::S_SCAN;
                end
            end
            thtc_pkg::S_SCAN:
            begin
                if (status.seg_hit)
                begin
                    cmd.scan_hit = 1'b1;
                    state_next   = thtc_pkg::S_MUL;
                end
                else if (status.scan_end)
                begin
                    cmd.res_sel = thtc_pkg::RES_ZERO;
                    state_next  = thtc_pkg::S_DONE;
                end
                else
                begin
                    cmd.scan_adv = 1'b1;
                    cmd.addr_sel = thtc_pkg::ADDR_IDX;
                end
            end
            thtc_pkg::S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = thtc_pkg::S_DIV;
            end
            thtc_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = thtc_pkg::S_FIN;
                end
            end
            thtc_pkg::S_FIN:
            begin
                cmd.res_sel = thtc_pkg::RES_INTERP;
                state_next  = thtc_pkg::S_DONE;
            end
            thtc_pkg::S_DONE:
            begin
                state_next = thtc_pkg::S_IDLE;
            end
            default:
            begin
                state_next = thtc_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != thtc_pkg::S_IDLE);
    assign done = (state_reg == thtc_pkg::S_DONE);

endmodule

`default_nettype wire

FILE: src/thtc_dp.sv
// Table memory, segment search registers and restoring divider.
`default_nettype none

module thtc_dp (
    input  wire logic                                 clk,
    input  wire thtc_pkg::cmd_t                       cmd,
    input  wire logic                                 table_select,
    input  wire logic [4:0]                           entry_index,
    input  wire logic signed [thtc_pkg::VAL_W-1:0]    entry_value,
    input  wire logic signed [thtc_pkg::VAL_W-1:0]    raw_reading,
    output thtc_pkg::status_t                         status,
    output logic signed [thtc_pkg::TEMP_W-1:0]        temperature_tenths,
    output logic                                      thermistor_id
);

    localparam int AW = thtc_pkg::ADDR_W;
    localparam int IW = thtc_pkg::IDX_W;
    localparam int VW = thtc_pkg::VAL_W;
    localparam int NW = thtc_pkg::NUM_W;
    localparam int QW = thtc_pkg::QUO_W;
    localparam int BW = thtc_pkg::BASE_W;

    logic [VW-1:0] mem [0:thtc_pkg::MEM_DEPTH-1];

    logic signed [VW-1:0] rd_data_reg;
    logic signed [VW-1:0] raw_reg;
    logic                 sel_reg;
    logic signed [VW-1:0] hi_reg;
    logic [IW-1:0]        idx_reg;
    logic                 last_hit_reg;
    logic signed [BW-1:0] base_reg;
    logic [VW-1:0]        x_reg;
    logic [VW-1:0]        d_reg;
    logic [NW-1:0]        num_reg;
    logic [NW-1:0]        dv_reg;
    logic [QW-1:0]        quo_reg;
    logic [thtc_pkg::CNT_W-1:0] cnt_reg;
    logic signed [thtc_pkg::TEMP_W-1:0] res_reg;

    logic [IW-1:0]        rd_idx;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic                 wr_en;
    logic [VW:0]          x_full;
    logic [VW:0]          d_full;
    logic signed [BW-1:0] interp;

    // Load: ignore entries past the table end
    assign wr_en   = cmd.load && (32'(entry_index) < 32'(thtc_pkg::TABLE_ENTRIES));
    assign wr_addr = table_select ? AW'(thtc_pkg::TABLE_ENTRIES) + AW'(entry_index)
                                  : AW'(entry_index);

    always_comb
    begin
        case (cmd.addr_sel)
            thtc_pkg::ADDR_LAST: rd_idx = IW'(thtc_pkg::TABLE_ENTRIES - 1);
            thtc_pkg::ADDR_ZERO: rd_idx = '0;
            thtc_pkg::ADDR_IDX:  rd_idx = idx_reg;
            default:             rd_idx = idx_reg;
        endcase
    end

    assign rd_addr = sel_reg ? AW'(thtc_pkg::TABLE_ENTRIES) + AW'(rd_idx) : AW'(rd_idx);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= entry_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign x_full = {hi_reg[VW-1], hi_reg} - {raw_reg[VW-1], raw_reg};
    assign d_full = {hi_reg[VW-1], hi_reg} - {rd_data_reg[VW-1], rd_data_reg};
    assign interp = base_reg + $signed({{(BW-QW){1'b0}}, quo_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            raw_reg <= raw_reading;
            sel_reg <= table_select;
        end
        if (cmd.chk_last)
        begin
            last_hit_reg <= (raw_reg <= rd_data_reg);
        end
        case (cmd.addr_sel)
            thtc_pkg::ADDR_ZERO: idx_reg <= IW'(1);
            thtc_pkg::ADDR_IDX:  idx_reg <= idx_reg + IW'(1);
            default:             idx_reg <= idx_reg;
        endcase
        if (cmd.scan_init)
        begin
            hi_reg   <= rd_data_reg;
            base_reg <= BW'(thtc_pkg::LOW_TENTHS);
        end
        if (cmd.scan_adv)
        begin
            hi_reg   <= rd_data_reg;
            base_reg <= base_reg + BW'(thtc_pkg::SEG_TENTHS);
        end
        if (cmd.scan_hit)
        begin
            x_reg <= x_full[VW-1:0];
            d_reg <= d_full[VW-1:0];
        end
        if (cmd.mul)
        begin
            num_reg <= NW'(x_reg) * NW'(thtc_pkg::SEG_TENTHS);
            dv_reg  <= NW'(d_reg) << (QW - 1);
            cnt_reg <= thtc_pkg::CNT_W'(QW - 1);
            quo_reg <= '0;
        end
        if (cmd.div_step)
        begin
            if (num_reg >= dv_reg)
            begin
                num_reg <= num_reg - dv_reg;
                quo_reg <= {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                quo_reg <= {quo_reg[QW-2:0], 1'b0};
            end
            dv_reg  <= dv_reg >> 1;
            cnt_reg <= cnt_reg - thtc_pkg::CNT_W'(1);
        end
        case (cmd.res_sel)
            thtc_pkg::RES_LOW:    res_reg <= thtc_pkg::LOW_SAT;
            thtc_pkg::RES_TOP:    res_reg <= thtc_pkg::TOP_SAT;
            thtc_pkg::RES_ZERO:   res_reg <= '0;
            thtc_pkg::RES_INTERP: res_reg <= thtc_pkg::sat_temp(interp);
            default:              res_reg <= res_reg;
        endcase
    end

    assign status.gt_first = (raw_reg > rd_data_reg);
    assign status.last_hit = last_hit_reg;
    assign status.seg_hit  = (hi_reg >= raw_reg) && (raw_reg > rd_data_reg);
    assign status.scan_end = (idx_reg == IW'(thtc_pkg::TABLE_ENTRIES));
    assign status.div_last = (cnt_reg == '0);

    assign temperature_tenths = res_reg;
    assign thermistor_id      = sel_reg;

endmodule

`default_nettype wire

FILE: src/thermistor_table_to_temperature.sv
// Top level of the thermistor raw-reading to temperature converter.
`default_nettype none

// Converts a signed raw thermistor reading to tenths of a degree Celsius using
// one of two falling calibration tables (main, sub) of TABLE_ENTRIES points,
// one point per 5 C from -20 C. A beat is taken when start is high and busy
// is low. A load beat (mode = 1) writes one table entry in the same edge and
// leaves busy low, so loads may stream one per cycle; an index past the table
// end is dropped. A convert beat (mode = 0) raises busy and, some cycles
// later, pulses done for exactly one cycle with temperature_tenths and
// thermistor_id valid in that cycle only: the receiver cannot stall, so it
// must capture the result on that pulse. Table entries must be written before
// a conversion reads them.
//
// Course of a convert beat: the last and then the first table entry are
// read, and a reading outside the table ends there. Otherwise the table,
// which has a single read port, is walked one entry per cycle until i, the
// index of the matching segment, is found; then the multiply step, the
// restoring divider that makes one quotient bit per cycle, and a final step
// give the result. When no segment matches, the walk runs to the table end.
// busy drops the cycle after done.
//
// Interpolation: the result is 10*(-20 + 5*i) + floor(50*(t[i]-raw) / d),
// d = t[i]-t[i+1]; the single six-bit quotient carries both the whole degrees
// and the truncated tenths digit.
module thermistor_table_to_temperature (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic                                 mode,
    input  wire logic                                 table_select,
    input  wire logic [4:0]                           entry_index,
    input  wire logic signed [thtc_pkg::VAL_W-1:0]    entry_value,
    input  wire logic signed [thtc_pkg::VAL_W-1:0]    raw_reading,
    output logic                                      done,
    output logic signed [thtc_pkg::TEMP_W-1:0]        temperature_tenths,
    output logic                                      thermistor_id
);

    thtc_pkg::cmd_t    cmd;
    thtc_pkg::status_t status;

    thtc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (mode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    thtc_dp u_dp (
        .clk                (clk),
        .cmd                (cmd),
        .table_select       (table_select),
        .entry_index        (entry_index),
        .entry_value        (entry_value),
        .raw_reading        (raw_reading),
        .status             (status),
        .temperature_tenths (temperature_tenths),
        .thermistor_id      (thermistor_id)
    );

    // Convert beat must occupy the sequencer
    a_convert_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !mode) |=> busy)
        else $error("convert beat did not raise busy");

    // Load beat is absorbed without a result
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode) |=> (!busy && !done))
        else $error("load beat started a conversion");

    // Result pulse is one cycle and returns to idle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("done not a single-cycle pulse");

    // Result stays within the table span
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (temperature_tenths >= thtc_pkg::LOW_SAT &&
                  temperature_tenths <= thtc_pkg::TOP_SAT))
        else $error("temperature outside table span");

endmodule

`default_nettype wire
